[hdl/dsa_pkg.sv]
package dsa_pkg;

    // Default depth of the descriptor slot table.
    localparam int TABLE_DEPTH_DEF = 1024;

    // Field widths of the channels.
    localparam int OP_W       = 2;
    localparam int SLOT_W     = 10;
    localparam int STATUS_W   = 3;
    localparam int CAP_W      = 11;
    localparam int STRIDE_W   = 13;
    localparam int HANDLE_W   = 64;
    localparam int LIVE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Register values after reset.
    localparam int                  CAPACITY_RST = 1024;
    localparam logic [STRIDE_W-1:0] STRIDE_RST   = 13'd32;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_REINIT = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_RANGE_ERR = 3'd3,
        ST_IN_USE    = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_STRIDE   = 2'd1,
        CFG_CPU_BASE = 2'd2,
        CFG_GPU_BASE = 2'd3
    } cfg_idx_t;

    // A classified command as it waits in the queue.
    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic              beyond_cap;
        logic              cap_zero;
    } cmd_t;

    // Handle generation settings passed from the front to the back.
    typedef struct packed {
        logic [STRIDE_W-1:0] stride;
        logic [HANDLE_W-1:0] cpu_base;
        logic [HANDLE_W-1:0] gpu_base;
    } handle_cfg_t;

endpackage

[hdl/dsa_intf.sv]
// Request channel: one command per transfer.
interface dsa_req_if;
    logic                       valid;
    logic                       ready;
    logic [dsa_pkg::OP_W-1:0]   op;
    logic [dsa_pkg::SLOT_W-1:0] slot;

    modport source (output valid, op, slot, input ready);
    modport sink   (input valid, op, slot, output ready);
endinterface

// Response channel: one result per command.
interface dsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [dsa_pkg::STATUS_W-1:0] status;
    logic [dsa_pkg::SLOT_W-1:0]   granted_slot;
    logic [dsa_pkg::HANDLE_W-1:0] cpu_handle;
    logic [dsa_pkg::HANDLE_W-1:0] gpu_handle;
    logic                         slot_in_use;
    logic [dsa_pkg::LIVE_W-1:0]   live_count;

    modport source (output valid, status, granted_slot, cpu_handle, gpu_handle,
                     slot_in_use, live_count, input ready);
    modport sink   (input valid, status, granted_slot, cpu_handle, gpu_handle,
                     slot_in_use, live_count, output ready);
endinterface

// Configuration write channel.
interface dsa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dsa_pkg::CFG_IDX_W-1:0]  index;
    logic [dsa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/dsa_front.sv]
module dsa_front #(
    parameter int TABLE_DEPTH = dsa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    dsa_req_if.sink                             req,
    dsa_cfg_if.sink                             cfg,
    input  logic                                clearing,
    input  logic                                q_full,
    output logic                                q_push,
    output dsa_pkg::cmd_t                       q_cmd,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    cap,
    output dsa_pkg::handle_cfg_t                hcfg
);

    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > dsa_pkg::CAP_W) ? CNT_W : dsa_pkg::CAP_W;
    localparam int CAP_RST = (dsa_pkg::CAPACITY_RST < TABLE_DEPTH) ?
                             dsa_pkg::CAPACITY_RST : TABLE_DEPTH;

    logic [CNT_W-1:0]              cap_reg;
    logic [CNT_W-1:0]              cap_next;
    logic [CMP_W-1:0]              cap_wide;
    logic [dsa_pkg::STRIDE_W-1:0]  stride_reg;
    logic [dsa_pkg::HANDLE_W-1:0]  cpu_base_reg;
    logic [dsa_pkg::HANDLE_W-1:0]  gpu_base_reg;

    // The written capacity is clamped to the table depth once, at write time.
    always_comb
    begin
        cap_wide = CMP_W'(cfg.data[dsa_pkg::CAP_W-1:0]);
        if (cap_wide > CMP_W'(TABLE_DEPTH))
        begin
            cap_next = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            cap_next = CNT_W'(cap_wide);
        end
    end

    // Configuration registers; every write transfer is taken at once.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CNT_W'(CAP_RST);
            stride_reg   <= dsa_pkg::STRIDE_RST;
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (dsa_pkg::cfg_idx_t'(cfg.index))
                dsa_pkg::CFG_CAPACITY: cap_reg      <= cap_next;
                dsa_pkg::CFG_STRIDE:   stride_reg   <= cfg.data[dsa_pkg::STRIDE_W-1:0];
                dsa_pkg::CFG_CPU_BASE: cpu_base_reg <= cfg.data;
                dsa_pkg::CFG_GPU_BASE: gpu_base_reg <= cfg.data;
                default:               cap_reg      <= cap_reg;
            endcase
        end
    end

    assign cap           = cap_reg;
    assign hcfg.stride   = stride_reg;
    assign hcfg.cpu_base = cpu_base_reg;
    assign hcfg.gpu_base = gpu_base_reg;

    // Requests are taken while the queue has room and the mark sweep is over.
    assign req.ready = !q_full && !clearing;
    assign q_push    = req.valid && req.ready;

    // Classify the command: range check against the capacity in force.
    always_comb
    begin
        q_cmd.op         = dsa_pkg::op_t'(req.op);
        q_cmd.slot       = req.slot;
        q_cmd.beyond_cap = CMP_W'(req.slot) >= CMP_W'(cap_reg);
        q_cmd.cap_zero   = (cap_reg == '0);
    end

endmodule

[hdl/dsa_queue.sv]
module dsa_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dsa_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output dsa_pkg::cmd_t head
);

    dsa_pkg::cmd_t                     entries_reg [dsa_pkg::QUEUE_DEPTH];
    logic [dsa_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [dsa_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [dsa_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [dsa_pkg::QUEUE_CNT_W-1:0]   count_next;

    assign full       = (count_reg == dsa_pkg::QUEUE_CNT_W'(dsa_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[hdl/dsa_back.sv]
module dsa_back #(
    parameter int TABLE_DEPTH = dsa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]  cap,
    input  dsa_pkg::handle_cfg_t              hcfg,
    input  logic                              head_valid,
    input  dsa_pkg::cmd_t                     head,
    output logic                              pop,
    output logic                              clearing,
    dsa_rsp_if.source                         rsp
);

    localparam int SW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int OFF_W = dsa_pkg::STRIDE_W + SW;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_MUL   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Allocator state.
    logic [SW-1:0]    clr_idx_reg;
    logic [CNT_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Command in progress and its result.
    dsa_pkg::cmd_t     wcmd_reg;
    logic [SW-1:0]     wslot;
    logic [SW-1:0]     g_reg, g_next;
    dsa_pkg::status_t  status_reg, status_next;
    logic              handles_reg, handles_next;
    logic              mark_reg, mark_next;
    logic [OFF_W-1:0]  off_reg;

    // Memories and their ports.
    logic              marks_mem [TABLE_DEPTH];
    logic [SW-1:0]     stack_mem [TABLE_DEPTH];
    logic              mark_rd_reg;
    logic [SW-1:0]     stack_rd_reg;
    logic              mark_we;
    logic [SW-1:0]     mark_waddr;
    logic              mark_wdata;
    logic              stack_we;

    // Output register.
    logic                          load_out;
    logic                          out_valid_reg;
    dsa_pkg::status_t              out_status_reg;
    logic [dsa_pkg::SLOT_W-1:0]    out_slot_reg;
    logic [dsa_pkg::HANDLE_W-1:0]  out_cpu_reg;
    logic [dsa_pkg::HANDLE_W-1:0]  out_gpu_reg;
    logic                          out_mark_reg;
    logic [dsa_pkg::LIVE_W-1:0]    out_live_reg;

    assign clearing = (state_reg == S_CLEAR);
    assign wslot    = SW'(wcmd_reg.slot);

    // Sequencer: sweep the marks after reset, then one command at a time.
    always_comb
    begin
        state_next   = state_reg;
        top_next     = top_reg;
        fresh_next   = fresh_reg;
        cnt_next     = cnt_reg;
        g_next       = g_reg;
        status_next  = status_reg;
        handles_next = handles_reg;
        mark_next    = mark_reg;
        mark_we      = 1'b0;
        mark_waddr   = clr_idx_reg;
        mark_wdata   = 1'b0;
        stack_we     = 1'b0;
        pop          = 1'b0;
        load_out     = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mark_we = 1'b1;
                if (clr_idx_reg == SW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                status_next  = dsa_pkg::ST_OK;
                handles_next = 1'b0;
                mark_next    = 1'b0;
                g_next       = '0;
                state_next   = S_MUL;
                case (wcmd_reg.op)
                    dsa_pkg::OP_ALLOC:
                    begin
                        if (top_reg != '0)
                        begin
                            // Reuse the most recently freed slot.
                            top_next = top_reg - 1'b1;
                            if (CNT_W'(stack_rd_reg) >= cap)
                            begin
                                status_next = dsa_pkg::ST_RANGE_ERR;
                            end
                            else
                            begin
                                g_next       = stack_rd_reg;
                                handles_next = 1'b1;
                                mark_next    = 1'b1;
                                mark_we      = 1'b1;
                                mark_waddr   = stack_rd_reg;
                                mark_wdata   = 1'b1;
                                cnt_next     = cnt_reg + 1'b1;
                            end
                        end
                        else if (fresh_reg < cap)
                        begin
                            // Hand out a never-used slot.
                            fresh_next   = fresh_reg + 1'b1;
                            g_next       = SW'(fresh_reg);
                            handles_next = 1'b1;
                            mark_next    = 1'b1;
                            mark_we      = 1'b1;
                            mark_waddr   = SW'(fresh_reg);
                            mark_wdata   = 1'b1;
                            cnt_next     = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = dsa_pkg::ST_EXHAUSTED;
                        end
                    end

                    dsa_pkg::OP_FREE:
                    begin
                        if (wcmd_reg.beyond_cap)
                        begin
                            status_next = dsa_pkg::ST_RANGE_ERR;
                        end
                        else if (!mark_rd_reg)
                        begin
                            status_next = dsa_pkg::ST_NOT_ALLOC;
                        end
                        else
                        begin
                            mark_we    = 1'b1;
                            mark_waddr = wslot;
                            mark_wdata = 1'b0;
                            if (top_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                stack_we = 1'b1;
                                top_next = top_reg + 1'b1;
                            end
                            if (cnt_reg != '0)
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                    end

                    dsa_pkg::OP_LOOKUP:
                    begin
                        if (wcmd_reg.beyond_cap)
                        begin
                            status_next = dsa_pkg::ST_RANGE_ERR;
                        end
                        else
                        begin
                            g_next       = wslot;
                            handles_next = 1'b1;
                            mark_next    = mark_rd_reg;
                        end
                    end

                    dsa_pkg::OP_REINIT:
                    begin
                        if (wcmd_reg.cap_zero)
                        begin
                            status_next = dsa_pkg::ST_RANGE_ERR;
                        end
                        else if (cnt_reg != '0)
                        begin
                            status_next = dsa_pkg::ST_IN_USE;
                        end
                        else
                        begin
                            top_next   = '0;
                            fresh_next = '0;
                        end
                    end

                    default:
                    begin
                        status_next = dsa_pkg::ST_OK;
                    end
                endcase
            end

            S_MUL:
            begin
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            top_reg       <= '0;
            fresh_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            top_reg   <= top_next;
            fresh_reg <= fresh_next;
            cnt_reg   <= cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers, handle offset and result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            wcmd_reg <= head;
        end
        g_reg       <= g_next;
        status_reg  <= status_next;
        handles_reg <= handles_next;
        mark_reg    <= mark_next;
        if (state_reg == S_MUL)
        begin
            off_reg <= OFF_W'(hcfg.stride) * OFF_W'(g_reg);
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_slot_reg   <= handles_reg ? dsa_pkg::SLOT_W'(g_reg) : '0;
            out_cpu_reg    <= handles_reg ?
                              hcfg.cpu_base + dsa_pkg::HANDLE_W'(off_reg) : '0;
            out_gpu_reg    <= handles_reg ?
                              hcfg.gpu_base + dsa_pkg::HANDLE_W'(off_reg) : '0;
            out_mark_reg   <= mark_reg;
            out_live_reg   <= dsa_pkg::LIVE_W'(cnt_reg);
        end
    end

    // Slot mark memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            marks_mem[mark_waddr] <= mark_wdata;
        end
        if (pop)
        begin
            mark_rd_reg <= marks_mem[SW'(head.slot)];
        end
    end

    // Free stack memory: pushes at the top, reads just below it.
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[SW'(top_reg)] <= wslot;
        end
        if (pop)
        begin
            stack_rd_reg <= stack_mem[SW'(top_reg - 1'b1)];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.granted_slot = out_slot_reg;
    assign rsp.cpu_handle   = out_cpu_reg;
    assign rsp.gpu_handle   = out_gpu_reg;
    assign rsp.slot_in_use  = out_mark_reg;
    assign rsp.live_count   = out_live_reg;

    // The stack pointer never passes the table depth.
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= CNT_W'(TABLE_DEPTH))
        else $error("free stack pointer beyond table depth");

    // The live count never passes the table depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("live count beyond table depth");

    // A loaded result is presented and the sequencer is free again.
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && load_out) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("result load did not complete");

    // A granted allocation raises the live count by one.
    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && wcmd_reg.op == dsa_pkg::OP_ALLOC
         && status_next == dsa_pkg::ST_OK)
        |=> cnt_reg == CNT_W'($past(cnt_reg) + 1'b1))
        else $error("allocation did not count the slot");

    // A successful free pushes the slot onto the stack.
    a_free_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && wcmd_reg.op == dsa_pkg::OP_FREE
         && status_next == dsa_pkg::ST_OK && top_reg < CNT_W'(TABLE_DEPTH))
        |=> top_reg == CNT_W'($past(top_reg) + 1'b1))
        else $error("freed slot not pushed");

endmodule

[hdl/descriptor_slot_allocator_top.sv]
// Channel  Role   Handshake     Payload
// req      sink   valid/ready   op, slot
// rsp      source valid/ready   status, granted_slot, cpu_handle, gpu_handle,
//                               slot_in_use, live_count
// cfg      sink   valid/ready   index, data (ready is always high)
//
// The back sequencer takes each command through its steps in order (dequeue with
// memory read, decide and update, handle multiply, handle add into the output
// register) and takes the next command only after the last one is loaded there.
// After reset the slot marks are swept; req.ready stays low meanwhile, while
// configuration writes are taken.
// The two-entry command queue takes requests until it is full while a result waits on
// rsp; the sequencer holds a finished result until the output register frees.
module descriptor_slot_allocator_top #(
    parameter int TABLE_DEPTH = dsa_pkg::TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dsa_req_if.sink    req,
    dsa_rsp_if.source  rsp,
    dsa_cfg_if.sink    cfg
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic                  clearing;
    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  head_valid;
    dsa_pkg::cmd_t         q_cmd;
    dsa_pkg::cmd_t         head;
    logic [CNT_W-1:0]      cap;
    dsa_pkg::handle_cfg_t  hcfg;

    // Front: configuration registers and command classification.
    dsa_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .cap      (cap),
        .hcfg     (hcfg)
    );

    // Command queue between the two halves.
    dsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .cmd_in     (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back: slot bookkeeping, handle generation and result register.
    dsa_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cap        (cap),
        .hcfg       (hcfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (q_pop),
        .clearing   (clearing),
        .rsp        (rsp)
    );

endmodule

[test/descriptor_slot_allocator_top_test.sv]
`timescale 1ns / 1ps

module descriptor_slot_allocator_top_test;

    localparam int          DEPTH        = dsa_pkg::TABLE_DEPTH_DEF;
    localparam int          RANDOM_ITEMS = 980;
    localparam int          QUIET_FROM   = 850;
    localparam int unsigned SETTLE_LIMIT = 10;

    // One response of the allocator, in the order of the response channel.
    typedef struct packed {
        dsa_pkg::status_t             status;
        logic [dsa_pkg::SLOT_W-1:0]   granted_slot;
        logic [dsa_pkg::HANDLE_W-1:0] cpu_handle;
        logic [dsa_pkg::HANDLE_W-1:0] gpu_handle;
        logic                         slot_in_use;
        logic [dsa_pkg::LIVE_W-1:0]   live_count;
    } alloc_result_t;

    typedef enum bit {ROW_REQUEST, ROW_WRITE} row_kind_t;

    // One line of the directed script: a command or a register write.
    typedef struct {
        row_kind_t                  kind;
        dsa_pkg::cfg_idx_t          reg_idx;
        logic [63:0]                reg_val;
        dsa_pkg::op_t               op;
        logic [dsa_pkg::SLOT_W-1:0] slot;
        bit                         typed;
        alloc_result_t              want;
    } script_row_t;

    logic clk;
    logic rst_n;

    dsa_req_if req_ch ();
    dsa_rsp_if rsp_ch ();
    dsa_cfg_if cfg_ch ();

    descriptor_slot_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the allocator registers and state.
    logic [dsa_pkg::CAP_W-1:0]    cap_reg;
    logic [dsa_pkg::STRIDE_W-1:0] stride_reg;
    logic [dsa_pkg::HANDLE_W-1:0] cpu_base_reg;
    logic [dsa_pkg::HANDLE_W-1:0] gpu_base_reg;
    logic [dsa_pkg::SLOT_W-1:0]   slot_stack [DEPTH];
    int unsigned                  stack_fill;
    int unsigned                  fresh_ptr;
    bit                           slot_busy [DEPTH];
    int unsigned                  busy_count;

    alloc_result_t pending_results [$];
    script_row_t   script [$];

    int  error_count;
    int  checked_count;
    int  write_count;
    int  phase_count;
    int  op_count [4];
    int  status_count [5];
    bit  quiet;
    bit  gaps_on;
    bit  stalls_on;

    // Free-running clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit, far above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Number of slots that can actually be handed out.
    function automatic int unsigned usable_slots();
        return (cap_reg < DEPTH) ? int'(cap_reg) : DEPTH;
    endfunction

    function automatic logic [dsa_pkg::HANDLE_W-1:0] handle_at(
        logic [dsa_pkg::HANDLE_W-1:0] base, int unsigned slot);
        return base + dsa_pkg::HANDLE_W'(stride_reg) * dsa_pkg::HANDLE_W'(slot);
    endfunction

    // Apply one command to the shadow state and return the response it causes.
    function automatic alloc_result_t allocator_step(dsa_pkg::op_t op,
                                                     logic [dsa_pkg::SLOT_W-1:0] slot);
        alloc_result_t r;
        int unsigned   lim;
        int unsigned   g;
        bit            hit;
        r   = '0;
        lim = usable_slots();
        hit = 1'b0;
        g   = 0;
        case (op)
            dsa_pkg::OP_ALLOC:
            begin
                if (stack_fill > 0)
                begin
                    stack_fill--;
                    g = slot_stack[stack_fill];
                    // A recycled slot at or above a lowered capacity is dropped.
                    if (g >= lim)
                        r.status = dsa_pkg::ST_RANGE_ERR;
                    else
                        hit = 1'b1;
                end
                else if (fresh_ptr < lim)
                begin
                    g = fresh_ptr;
                    fresh_ptr++;
                    hit = 1'b1;
                end
                else
                    r.status = dsa_pkg::ST_EXHAUSTED;
                if (hit)
                begin
                    slot_busy[g] = 1'b1;
                    busy_count++;
                    r.granted_slot = dsa_pkg::SLOT_W'(g);
                    r.cpu_handle   = handle_at(cpu_base_reg, g);
                    r.gpu_handle   = handle_at(gpu_base_reg, g);
                    r.slot_in_use  = 1'b1;
                end
            end
            dsa_pkg::OP_FREE:
            begin
                if (slot >= lim)
                    r.status = dsa_pkg::ST_RANGE_ERR;
                else if (!slot_busy[slot])
                    r.status = dsa_pkg::ST_NOT_ALLOC;
                else
                begin
                    slot_busy[slot] = 1'b0;
                    if (stack_fill < DEPTH)
                    begin
                        slot_stack[stack_fill] = slot;
                        stack_fill++;
                    end
                    if (busy_count > 0)
                        busy_count--;
                end
            end
            dsa_pkg::OP_LOOKUP:
            begin
                if (slot >= lim)
                    r.status = dsa_pkg::ST_RANGE_ERR;
                else
                begin
                    r.granted_slot = slot;
                    r.cpu_handle   = handle_at(cpu_base_reg, slot);
                    r.gpu_handle   = handle_at(gpu_base_reg, slot);
                    r.slot_in_use  = slot_busy[slot];
                end
            end
            default:
            begin
                if (lim == 0)
                    r.status = dsa_pkg::ST_RANGE_ERR;
                else if (busy_count != 0)
                    r.status = dsa_pkg::ST_IN_USE;
                else
                begin
                    stack_fill = 0;
                    fresh_ptr  = 0;
                end
            end
        endcase
        r.live_count = dsa_pkg::LIVE_W'(busy_count);
        return r;
    endfunction

    // A slot that is currently allocated and in range, or any slot if none is.
    function automatic logic [dsa_pkg::SLOT_W-1:0] busy_slot_or_any();
        int unsigned lim;
        int unsigned start;
        int unsigned k;
        lim = usable_slots();
        if (lim != 0)
        begin
            start = $urandom_range(0, lim - 1);
            for (k = 0; k < lim; k++)
                if (slot_busy[(start + k) % lim])
                    return dsa_pkg::SLOT_W'((start + k) % lim);
        end
        return dsa_pkg::SLOT_W'($urandom_range(0, DEPTH - 1));
    endfunction

    function automatic logic [dsa_pkg::HANDLE_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom_range(0, 4095));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void add_request(dsa_pkg::op_t op, int slot);
        script_row_t row;
        row.kind    = ROW_REQUEST;
        row.reg_idx = dsa_pkg::CFG_CAPACITY;
        row.reg_val = '0;
        row.op      = op;
        row.slot    = dsa_pkg::SLOT_W'(slot);
        row.typed   = 1'b0;
        row.want    = '0;
        script.push_back(row);
    endfunction

    function automatic void add_checked(dsa_pkg::op_t op, int slot, dsa_pkg::status_t st,
                                        int granted, logic [63:0] cpu, logic [63:0] gpu,
                                        bit in_use, int live);
        script_row_t row;
        row.kind              = ROW_REQUEST;
        row.reg_idx           = dsa_pkg::CFG_CAPACITY;
        row.reg_val           = '0;
        row.op                = op;
        row.slot              = dsa_pkg::SLOT_W'(slot);
        row.typed             = 1'b1;
        row.want.status       = st;
        row.want.granted_slot = dsa_pkg::SLOT_W'(granted);
        row.want.cpu_handle   = cpu;
        row.want.gpu_handle   = gpu;
        row.want.slot_in_use  = in_use;
        row.want.live_count   = dsa_pkg::LIVE_W'(live);
        script.push_back(row);
    endfunction

    function automatic void add_write(dsa_pkg::cfg_idx_t idx, logic [63:0] val);
        script_row_t row;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        row.op      = dsa_pkg::OP_ALLOC;
        row.slot    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        script.push_back(row);
    endfunction

    function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Send one command; the expected response is queued at the transfer.
    task automatic send_request(dsa_pkg::op_t op, logic [dsa_pkg::SLOT_W-1:0] slot,
                                bit typed, alloc_result_t want);
        alloc_result_t predicted;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.slot  <= slot;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = allocator_step(op, slot);
        pending_results.push_back(typed ? want : predicted);
        op_count[op]++;
    endtask

    task automatic idle_request(int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    // Hold off the request side until every response has come back.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(dsa_pkg::cfg_idx_t idx, logic [63:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            dsa_pkg::CFG_CAPACITY: cap_reg      = val[dsa_pkg::CAP_W-1:0];
            dsa_pkg::CFG_STRIDE:   stride_reg   = val[dsa_pkg::STRIDE_W-1:0];
            dsa_pkg::CFG_CPU_BASE: cpu_base_reg = val;
            default:               gpu_base_reg = val;
        endcase
        write_count++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Response side: ready toggles in bursts unless stalls are off or the run is quiet.
    initial
    begin : rsp_driver
        int unsigned burst;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (!quiet && stalls_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 19);
                repeat (burst)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= 1'b0;
                end
            end
            else
            begin
                burst = $urandom_range(1, 30);
                repeat (burst)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Compare each response transfer with the oldest expectation.
    always @(posedge clk)
    begin : rsp_monitor
        alloc_result_t want;
        alloc_result_t seen;
        bit            same;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            seen.status       = dsa_pkg::status_t'(rsp_ch.status);
            seen.granted_slot = rsp_ch.granted_slot;
            seen.cpu_handle   = rsp_ch.cpu_handle;
            seen.gpu_handle   = rsp_ch.gpu_handle;
            seen.slot_in_use  = rsp_ch.slot_in_use;
            seen.live_count   = rsp_ch.live_count;
            if (pending_results.size() == 0)
            begin
                $display("%0t: expected no response, actual status %0h slot %0h",
                         $time, seen.status, seen.granted_slot);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                same = field_ok("status", want.status, seen.status)
                     & field_ok("granted_slot", want.granted_slot, seen.granted_slot)
                     & field_ok("cpu_handle", want.cpu_handle, seen.cpu_handle)
                     & field_ok("gpu_handle", want.gpu_handle, seen.gpu_handle)
                     & field_ok("slot_in_use", want.slot_in_use, seen.slot_in_use)
                     & field_ok("live_count", want.live_count, seen.live_count);
                if (!same)
                    error_count++;
                checked_count++;
                if (seen.status <= dsa_pkg::ST_IN_USE)
                    status_count[seen.status]++;
            end
        end
    end

    // Stimulus: reset, directed script, then randomized phases.
    initial
    begin : stimulus
        int unsigned                phase_len;
        int unsigned                n;
        int unsigned                r;
        int unsigned                lim;
        int unsigned                new_cap;
        int unsigned                random_sent;
        logic [dsa_pkg::SLOT_W-1:0] pick;
        dsa_pkg::op_t               op_sel;
        bit                         filling;

        req_ch.valid = 1'b0;
        req_ch.op    = dsa_pkg::OP_ALLOC;
        req_ch.slot  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = dsa_pkg::CFG_CAPACITY;
        cfg_ch.data  = '0;
        rst_n        = 1'b0;
        quiet        = 1'b0;
        gaps_on      = 1'b0;
        stalls_on    = 1'b1;
        error_count  = 0;
        random_sent  = 0;

        // Shadow state after reset.
        cap_reg      = dsa_pkg::CAP_W'(dsa_pkg::CAPACITY_RST);
        stride_reg   = dsa_pkg::STRIDE_RST;
        cpu_base_reg = '0;
        gpu_base_reg = '0;
        stack_fill   = 0;
        fresh_ptr    = 0;
        busy_count   = 0;
        foreach (slot_busy[i])
            slot_busy[i] = 1'b0;

        // Directed script. Rows with a typed response are the obvious ones.
        add_checked(dsa_pkg::OP_LOOKUP, 0,    dsa_pkg::ST_OK,        0, 0, 0, 1'b0, 0);
        add_checked(dsa_pkg::OP_FREE,   1023, dsa_pkg::ST_NOT_ALLOC, 0, 0, 0, 1'b0, 0);
        add_checked(dsa_pkg::OP_REINIT, 0,    dsa_pkg::ST_OK,        0, 0, 0, 1'b0, 0);
        add_checked(dsa_pkg::OP_ALLOC,  0,    dsa_pkg::ST_OK,        0, 0, 0, 1'b1, 1);
        add_checked(dsa_pkg::OP_ALLOC,  0,    dsa_pkg::ST_OK,        1, 32, 32, 1'b1, 2);
        add_checked(dsa_pkg::OP_REINIT, 0,    dsa_pkg::ST_IN_USE,    0, 0, 0, 1'b0, 2);
        add_request(dsa_pkg::OP_LOOKUP, 1023);
        add_request(dsa_pkg::OP_FREE, 1);
        add_checked(dsa_pkg::OP_FREE,   1,    dsa_pkg::ST_NOT_ALLOC, 0, 0, 0, 1'b0, 1);
        add_request(dsa_pkg::OP_ALLOC, 0);
        // A large stride and bases that make the handles wrap.
        add_write(dsa_pkg::CFG_STRIDE, 64'd4096);
        add_write(dsa_pkg::CFG_CPU_BASE, '1);
        add_write(dsa_pkg::CFG_GPU_BASE, 64'h8000_0000_0000_0000);
        add_request(dsa_pkg::OP_ALLOC, 0);
        add_request(dsa_pkg::OP_LOOKUP, 1023);
        // Lower the capacity under a slot that sits on the free stack.
        add_write(dsa_pkg::CFG_CAPACITY, 64'd3);
        add_request(dsa_pkg::OP_FREE, 2);
        add_write(dsa_pkg::CFG_CAPACITY, 64'd2);
        add_checked(dsa_pkg::OP_ALLOC,  0, dsa_pkg::ST_RANGE_ERR, 0, 0, 0, 1'b0, 2);
        add_checked(dsa_pkg::OP_ALLOC,  0, dsa_pkg::ST_EXHAUSTED, 0, 0, 0, 1'b0, 2);
        add_checked(dsa_pkg::OP_LOOKUP, 2, dsa_pkg::ST_RANGE_ERR, 0, 0, 0, 1'b0, 2);
        add_request(dsa_pkg::OP_FREE, 0);
        add_request(dsa_pkg::OP_FREE, 1);
        add_checked(dsa_pkg::OP_REINIT, 0, dsa_pkg::ST_OK,        0, 0, 0, 1'b0, 0);
        // Zero capacity: nothing to hand out and reinitialize is refused.
        add_write(dsa_pkg::CFG_CAPACITY, 64'd0);
        add_checked(dsa_pkg::OP_ALLOC,  0, dsa_pkg::ST_EXHAUSTED, 0, 0, 0, 1'b0, 0);
        add_checked(dsa_pkg::OP_REINIT, 0, dsa_pkg::ST_RANGE_ERR, 0, 0, 0, 1'b0, 0);
        // Capacity above the table depth is clipped to it.
        add_write(dsa_pkg::CFG_CAPACITY, 64'd2047);
        add_write(dsa_pkg::CFG_STRIDE, 64'd0);
        add_checked(dsa_pkg::OP_REINIT, 0, dsa_pkg::ST_OK,        0, 0, 0, 1'b0, 0);
        add_request(dsa_pkg::OP_ALLOC, 0);
        add_request(dsa_pkg::OP_FREE, 0);

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed script.
        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                send_request(script[i].op, script[i].slot, script[i].typed, script[i].want);
        end

        // Random phases, each under its own register setting.
        while (random_sent < RANDOM_ITEMS)
        begin
            // Sender holds off until all responses are in before reconfiguring.
            wait_idle();
            quiet     = (random_sent >= QUIET_FROM);
            gaps_on   = ($urandom_range(0, 2) != 0);
            stalls_on = ($urandom_range(0, 2) != 0);

            case ($urandom_range(0, 9))
                0:       new_cap = 1;
                1:       new_cap = 2;
                2, 3, 4: new_cap = $urandom_range(3, 20);
                5, 6:    new_cap = $urandom_range(21, 200);
                7:       new_cap = DEPTH;
                8:       new_cap = $urandom_range(900, DEPTH);
                default: new_cap = $urandom_range(0, 1) ? 0 : 2047;
            endcase
            write_reg(dsa_pkg::CFG_CAPACITY, 64'(new_cap));
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 5))
                    0:       write_reg(dsa_pkg::CFG_STRIDE, 64'd1);
                    1:       write_reg(dsa_pkg::CFG_STRIDE, 64'd4096);
                    2:       write_reg(dsa_pkg::CFG_STRIDE, 64'd8191);
                    3:       write_reg(dsa_pkg::CFG_STRIDE, 64'd0);
                    default: write_reg(dsa_pkg::CFG_STRIDE, 64'($urandom_range(1, 4096)));
                endcase
            end
            if ($urandom_range(0, 1))
                write_reg(dsa_pkg::CFG_CPU_BASE, pick_base());
            if ($urandom_range(0, 1))
                write_reg(dsa_pkg::CFG_GPU_BASE, pick_base());

            // First half mostly allocates, second half mostly frees.
            phase_len = $urandom_range(60, 140);
            filling   = 1'b1;
            for (n = 0; n < phase_len; n++)
            begin
                quiet = (random_sent >= QUIET_FROM);
                if (n == phase_len / 2)
                    filling = 1'b0;
                if (gaps_on && !quiet && $urandom_range(0, 3) == 0)
                    idle_request($urandom_range(1, 19));
                r   = $urandom_range(0, 99);
                lim = usable_slots();
                if (r < (filling ? 55 : 15))
                begin
                    op_sel = dsa_pkg::OP_ALLOC;
                    pick   = dsa_pkg::SLOT_W'($urandom_range(0, DEPTH - 1));
                end
                else if (r < (filling ? 80 : 75))
                begin
                    // Nothing left to free: close the cycle with a reinitialize.
                    op_sel = (busy_count == 0) ? dsa_pkg::OP_REINIT : dsa_pkg::OP_FREE;
                    pick   = busy_slot_or_any();
                end
                else if (r < (filling ? 90 : 88))
                begin
                    op_sel = dsa_pkg::OP_LOOKUP;
                    if ($urandom_range(0, 9) < 7)
                        pick = dsa_pkg::SLOT_W'($urandom_range(0,
                                   (lim + 1 < DEPTH) ? lim + 1 : DEPTH - 1));
                    else
                        pick = dsa_pkg::SLOT_W'($urandom_range(0, DEPTH - 1));
                end
                else if (r < (filling ? 96 : 95))
                begin
                    op_sel = dsa_pkg::op_t'($urandom_range(0, 3));
                    pick   = dsa_pkg::SLOT_W'($urandom_range(0, DEPTH - 1));
                end
                else
                begin
                    op_sel = dsa_pkg::OP_REINIT;
                    pick   = dsa_pkg::SLOT_W'($urandom_range(0, DEPTH - 1));
                end
                send_request(op_sel, pick, 1'b0, '0);
                random_sent++;
            end

            // Sometimes release every live slot below the capacity and start over.
            if ($urandom_range(0, 1))
            begin
                lim = usable_slots();
                for (n = 0; n < lim; n++)
                begin
                    if (slot_busy[n])
                    begin
                        quiet = (random_sent >= QUIET_FROM);
                        send_request(dsa_pkg::OP_FREE, dsa_pkg::SLOT_W'(n), 1'b0, '0);
                        random_sent++;
                    end
                end
                send_request(dsa_pkg::OP_REINIT,
                             dsa_pkg::SLOT_W'($urandom_range(0, DEPTH - 1)), 1'b0, '0);
                random_sent++;
            end
            phase_count++;
        end

        // Drain, then let any stray response arrive before the summary.
        wait_idle();
        repeat (SETTLE_LIMIT)
            @(posedge clk);

        $display("Ran %0d commands (%0d allocate, %0d free, %0d lookup, %0d reinit) %s",
                 op_count[dsa_pkg::OP_ALLOC] + op_count[dsa_pkg::OP_FREE]
                 + op_count[dsa_pkg::OP_LOOKUP] + op_count[dsa_pkg::OP_REINIT],
                 op_count[dsa_pkg::OP_ALLOC], op_count[dsa_pkg::OP_FREE],
                 op_count[dsa_pkg::OP_LOOKUP], op_count[dsa_pkg::OP_REINIT],
                 $sformatf("over %0d random settings and %0d register writes",
                           phase_count, write_count));
        $display("%0d responses checked: %0d ok, %0d exhausted, %0d not allocated, %s",
                 checked_count, status_count[dsa_pkg::ST_OK],
                 status_count[dsa_pkg::ST_EXHAUSTED], status_count[dsa_pkg::ST_NOT_ALLOC],
                 $sformatf("%0d out of range, %0d in use",
                           status_count[dsa_pkg::ST_RANGE_ERR],
                           status_count[dsa_pkg::ST_IN_USE]));
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
hdl/dsa_pkg.sv
hdl/dsa_intf.sv
hdl/dsa_front.sv
hdl/dsa_queue.sv
hdl/dsa_back.sv
hdl/descriptor_slot_allocator_top.sv
test/descriptor_slot_allocator_top_test.sv
